/* design/htw_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and helpers for the hierarchical timer wheel.
// No dependencies; imported by htw_place, the timer wheel unit and the testbench.
package htw_pkg;

  localparam int ID_W    = 6;
  localparam int DELAY_W = 32;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_CREATE  = 2'd1,
    CMD_REARM   = 2'd2,
    CMD_DESTROY = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    RS_OK       = 2'd0,
    RS_NOT_LIVE = 2'd1,
    RS_NO_FREE  = 2'd2
  } rsp_stat_e;

  typedef enum logic [1:0] {
    TS_FREE   = 2'd0,
    TS_IDLE   = 2'd1,
    TS_QUEUED = 2'd2
  } tstat_e;

  // Logical right shift that yields zero for shift counts of 32 and up.
  function automatic logic [31:0] shr32(logic [31:0] v, int unsigned s);
    shr32 = (s >= 32) ? 32'd0 : (v >> s);
  endfunction

endpackage

/* design/htw_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module htw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/htw_place.sv */
`timescale 1ns / 1ps
// Slot placement unit: maps an expiry and a reference tick to a wheel slot.
// Depends on htw_pkg (shr32). Result is registered.
module htw_place import htw_pkg::*; #(
  parameter int NEAR_BITS  = 8,
  parameter int FAR_BITS   = 6,
  parameter int FAR_LEVELS = 4,
  parameter int SW         = 9
) (
  input  logic          clk_i,
  input  logic [31:0]   exp_i,
  input  logic [31:0]   base_i,
  output logic [SW-1:0] slot_o
);

  localparam int NEAR_SIZE = 1 << NEAR_BITS;
  localparam int FAR_SIZE  = 1 << FAR_BITS;
  localparam int LVW       = (FAR_LEVELS > 1) ? $clog2(FAR_LEVELS) : 1;

  logic [31:0]    span;
  logic [LVW-1:0] lvl;
  logic           found;
  logic [31:0]    far_idx;
  logic [31:0]    slot_w;
  logic [SW-1:0]  slot_d, slot_q;

  always_comb begin
    span  = exp_i - base_i;
    lvl   = LVW'(FAR_LEVELS - 1);
    found = 1'b0;
    // pick the lowest far level whose span covers the distance
    for (int l = 0; l < FAR_LEVELS - 1; l++) begin
      if (!found && (shr32(span, NEAR_BITS + FAR_BITS * l) < 32'(FAR_SIZE))) begin
        lvl   = LVW'(l);
        found = 1'b1;
      end
    end
    far_idx = shr32(exp_i, NEAR_BITS + FAR_BITS * int'(lvl)) & 32'(FAR_SIZE - 1);
    if (span < 32'(NEAR_SIZE)) begin
      slot_w = exp_i & 32'(NEAR_SIZE - 1);
    end else begin
      slot_w = 32'(NEAR_SIZE) + (32'(lvl) << FAR_BITS) + far_idx;
    end
    slot_d = slot_w[SW-1:0];
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign slot_o = slot_q;

endmodule

/* design/hierarchical_timer_wheel_unit.sv */
`timescale 1ns / 1ps
// Hierarchical timer wheel: sequencer, list RAMs and free stack.
// Depends on htw_pkg, htw_ram and htw_place.
//
//  channel | handshake              | word
//  --------+------------------------+---------------------------------------------
//  in      | in_valid_i/in_ready_o  | cmd_i, timer_id_i, delay_ticks_i
//  out     | out_valid_o/out_ready_i| timer_id_out_o, expired_o, status_o,
//          |                        | was_pending_o, last_o
//
// Commands: a tick that wraps the near index also visits far levels and moves their timers;
//   every list step waits on the registered read of one RAM and shares one placement
//   unit.
// Reset: after rst_ni the block clears every wheel slot and every timer status, one
//   entry per cycle, with in_ready_o low.
// Stalls: the output word sits in a register; the sequencer holds before each output
//   while it is occupied and out_ready_i is low. in_ready_o is high only between commands.
module hierarchical_timer_wheel_unit import htw_pkg::*; #(
  parameter int NEAR_BITS   = 8,
  parameter int FAR_BITS    = 6,
  parameter int FAR_LEVELS  = 4,
  parameter int TIMER_COUNT = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         cmd_i,
  input  logic [ID_W-1:0]    timer_id_i,
  input  logic [DELAY_W-1:0] delay_ticks_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [ID_W-1:0]    timer_id_out_o,
  output logic               expired_o,
  output logic [1:0]         status_o,
  output logic               was_pending_o,
  output logic               last_o
);

  localparam int NEAR_SIZE = 1 << NEAR_BITS;
  localparam int FAR_SIZE  = 1 << FAR_BITS;
  localparam int SLOTS     = NEAR_SIZE + FAR_SIZE * FAR_LEVELS;
  localparam int SW        = $clog2(SLOTS);
  localparam int LW        = $clog2(SLOTS + 1);
  localparam int TIDW      = $clog2(TIMER_COUNT);
  localparam int PW        = TIDW + 1;
  localparam int LVW       = (FAR_LEVELS > 1) ? $clog2(FAR_LEVELS) : 1;
  // the clearing pass covers both the slot RAMs and the status RAM
  localparam int CLR_N     = (SLOTS > TIMER_COUNT) ? SLOTS : TIMER_COUNT;
  localparam int CW        = $clog2(CLR_N);
  // pointer with the top bit set marks the end of a list
  localparam logic [PW-1:0] NIL = {PW{1'b1}};
  // list number of the due list, one past the last wheel slot
  localparam logic [LW-1:0] DUE = LW'(SLOTS);

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_CHECK, ST_CR_GET, ST_UNLINK, ST_DESTROY, ST_QUEUE, ST_PLACED,
    ST_APP, ST_APP_LINK, ST_CAS_HEAD, ST_CAS_CLR, ST_CAS_WALK, ST_CAS_RD,
    ST_NEAR_RD, ST_NEAR_SPL, ST_DUE_RD, ST_DUE_NX, ST_DUE_EMIT, ST_RESP
  } state_e;

  state_e state_q, state_d, ret_q, ret_d;

  logic [31:0]      tick_q, tick_d;
  logic [PW-1:0]    free_top_q, free_top_d;
  logic [CW-1:0]    clr_q, clr_d;
  logic [PW-1:0]    due_head_q, due_head_d, due_tail_q, due_tail_d;
  logic [TIDW-1:0]  cur_q, cur_d;
  logic [PW-1:0]    walk_q, walk_d;
  logic [PW-1:0]    tlp_q, tlp_d;
  logic [LW-1:0]    lst_q, lst_d;
  logic [LVW-1:0]   lvl_q, lvl_d;
  logic [SW-1:0]    cslot_q, cslot_d;
  logic             czero_q, czero_d;
  logic             any_q, any_d;
  cmd_e             cmd_q, cmd_d;
  logic [31:0]      dly_q, dly_d;
  logic [ID_W-1:0]  rsp_id_q, rsp_id_d;
  rsp_stat_e        rsp_stat_q, rsp_stat_d;
  logic             rsp_wp_q, rsp_wp_d;
  logic             out_valid_q, out_valid_d;
  logic [ID_W-1:0]  out_id_q, out_id_d;
  logic             out_exp_q, out_exp_d;
  rsp_stat_e        out_stat_q, out_stat_d;
  logic             out_wp_q, out_wp_d;
  logic             out_last_q, out_last_d;

  logic [TIMER_COUNT-1:0] stk_vld_q;

  // status RAM ports
  logic             ts_we;
  logic [TIDW-1:0]  ts_idx, ts_raddr;
  tstat_e           ts_val;
  logic [1:0]       ts_rdata;

  // list RAM ports
  logic             hd_we, tl_we, nx_we, pv_we, ex_we, ls_we, sk_we;
  logic [SW-1:0]    hd_waddr, hd_raddr, tl_waddr, tl_raddr;
  logic [PW-1:0]    hd_wdata, hd_rdata, tl_wdata, tl_rdata;
  logic [TIDW-1:0]  nx_waddr, nx_raddr, pv_waddr, pv_raddr;
  logic [PW-1:0]    nx_wdata, nx_rdata, pv_wdata, pv_rdata;
  logic [TIDW-1:0]  ex_raddr, ls_raddr, sk_waddr, sk_raddr;
  logic [31:0]      ex_wdata, ex_rdata;
  logic [LW-1:0]    ls_rdata;
  logic [TIDW-1:0]  sk_wdata, sk_rdata;

  // placement unit
  logic [31:0]      pl_exp, pl_base;
  logic [SW-1:0]    pl_slot;

  // scratch
  logic [31:0]      tick_inc, cas_idx, cas_slot;
  logic [TIDW-1:0]  id_idx, pop_id;
  logic             id_ok, out_free;
  logic [PW-1:0]    tailv, up_p, up_n;
  logic [LW-1:0]    up_l;

  htw_ram #(.WIDTH(PW), .DEPTH(SLOTS)) u_head_ram (
    .clk_i, .we_i(hd_we), .waddr_i(hd_waddr), .wdata_i(hd_wdata),
    .raddr_i(hd_raddr), .rdata_o(hd_rdata));
  htw_ram #(.WIDTH(PW), .DEPTH(SLOTS)) u_tail_ram (
    .clk_i, .we_i(tl_we), .waddr_i(tl_waddr), .wdata_i(tl_wdata),
    .raddr_i(tl_raddr), .rdata_o(tl_rdata));
  htw_ram #(.WIDTH(PW), .DEPTH(TIMER_COUNT)) u_next_ram (
    .clk_i, .we_i(nx_we), .waddr_i(nx_waddr), .wdata_i(nx_wdata),
    .raddr_i(nx_raddr), .rdata_o(nx_rdata));
  htw_ram #(.WIDTH(PW), .DEPTH(TIMER_COUNT)) u_prev_ram (
    .clk_i, .we_i(pv_we), .waddr_i(pv_waddr), .wdata_i(pv_wdata),
    .raddr_i(pv_raddr), .rdata_o(pv_rdata));
  htw_ram #(.WIDTH(32), .DEPTH(TIMER_COUNT)) u_exp_ram (
    .clk_i, .we_i(ex_we), .waddr_i(cur_q), .wdata_i(ex_wdata),
    .raddr_i(ex_raddr), .rdata_o(ex_rdata));
  htw_ram #(.WIDTH(LW), .DEPTH(TIMER_COUNT)) u_list_ram (
    .clk_i, .we_i(ls_we), .waddr_i(cur_q), .wdata_i(lst_q),
    .raddr_i(ls_raddr), .rdata_o(ls_rdata));
  htw_ram #(.WIDTH(TIDW), .DEPTH(TIMER_COUNT)) u_stack_ram (
    .clk_i, .we_i(sk_we), .waddr_i(sk_waddr), .wdata_i(sk_wdata),
    .raddr_i(sk_raddr), .rdata_o(sk_rdata));
  htw_ram #(.WIDTH(2), .DEPTH(TIMER_COUNT)) u_stat_ram (
    .clk_i, .we_i(ts_we), .waddr_i(ts_idx), .wdata_i(ts_val),
    .raddr_i(ts_raddr), .rdata_o(ts_rdata));

  htw_place #(
    .NEAR_BITS(NEAR_BITS), .FAR_BITS(FAR_BITS), .FAR_LEVELS(FAR_LEVELS), .SW(SW)
  ) u_place (
    .clk_i, .exp_i(pl_exp), .base_i(pl_base), .slot_o(pl_slot));

  always_comb begin
    state_d    = state_q;
    ret_d      = ret_q;
    tick_d     = tick_q;
    free_top_d = free_top_q;
    clr_d      = clr_q;
    due_head_d = due_head_q;
    due_tail_d = due_tail_q;
    cur_d      = cur_q;
    walk_d     = walk_q;
    tlp_d      = tlp_q;
    lst_d      = lst_q;
    lvl_d      = lvl_q;
    cslot_d    = cslot_q;
    czero_d    = czero_q;
    any_d      = any_q;
    cmd_d      = cmd_q;
    dly_d      = dly_q;
    rsp_id_d   = rsp_id_q;
    rsp_stat_d = rsp_stat_q;
    rsp_wp_d   = rsp_wp_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_id_d   = out_id_q;
    out_exp_d  = out_exp_q;
    out_stat_d = out_stat_q;
    out_wp_d   = out_wp_q;
    out_last_d = out_last_q;

    ts_we = 1'b0; ts_idx = cur_q; ts_val = TS_IDLE; ts_raddr = '0;
    hd_we = 1'b0; hd_waddr = '0; hd_wdata = NIL; hd_raddr = '0;
    tl_we = 1'b0; tl_waddr = '0; tl_wdata = NIL; tl_raddr = '0;
    nx_we = 1'b0; nx_waddr = '0; nx_wdata = NIL; nx_raddr = '0;
    pv_we = 1'b0; pv_waddr = '0; pv_wdata = NIL; pv_raddr = '0;
    ex_we = 1'b0; ex_wdata = tick_q + dly_q; ex_raddr = '0;
    ls_we = 1'b0; ls_raddr = '0;
    sk_we = 1'b0; sk_waddr = free_top_q[TIDW-1:0]; sk_wdata = cur_q; sk_raddr = '0;
    pl_exp  = tick_q + dly_q;
    pl_base = tick_q + 32'd1;

    out_free = ~out_valid_q | out_ready_i;
    tick_inc = tick_q + 32'd1;
    id_idx   = timer_id_i[TIDW-1:0];
    id_ok    = 32'(timer_id_i) < 32'(TIMER_COUNT);
    // never-written stack entries still hold their reset order
    pop_id   = stk_vld_q[free_top_q[TIDW-1:0]] ? sk_rdata
             : TIDW'(TIMER_COUNT - 1) - free_top_q[TIDW-1:0];
    cas_idx  = shr32(tick_q, NEAR_BITS + FAR_BITS * int'(lvl_q)) & 32'(FAR_SIZE - 1);
    cas_slot = 32'(NEAR_SIZE) + (32'(lvl_q) << FAR_BITS) + cas_idx;
    tailv    = (lst_q == DUE) ? due_tail_q : tl_rdata;
    up_p     = pv_rdata;
    up_n     = nx_rdata;
    up_l     = ls_rdata;

    case (state_q)
      ST_CLEAR: begin
        if (32'(clr_q) < 32'(SLOTS)) begin
          hd_we = 1'b1; hd_waddr = clr_q[SW-1:0];
          tl_we = 1'b1; tl_waddr = clr_q[SW-1:0];
        end
        if (32'(clr_q) < 32'(TIMER_COUNT)) begin
          ts_we = 1'b1; ts_idx = clr_q[TIDW-1:0]; ts_val = TS_FREE;
        end
        clr_d = clr_q + 1'b1;
        if (clr_q == CW'(CLR_N - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d      = cmd_e'(cmd_i);
          dly_d      = delay_ticks_i;
          rsp_id_d   = timer_id_i;
          rsp_stat_d = RS_OK;
          rsp_wp_d   = 1'b0;
          any_d      = 1'b0;
          case (cmd_e'(cmd_i))
            CMD_TICK: begin
              tick_d = tick_inc;
              lvl_d  = '0;
              // near index wrapped: pull down the far levels first
              state_d = (tick_inc[NEAR_BITS-1:0] == '0) ? ST_CAS_HEAD : ST_NEAR_RD;
            end
            CMD_CREATE: begin
              rsp_id_d = '0;
              if (free_top_q == '0) begin
                rsp_stat_d = RS_NO_FREE;
                state_d    = ST_RESP;
              end else begin
                free_top_d = free_top_q - 1'b1;
                sk_raddr   = free_top_d[TIDW-1:0];
                state_d    = ST_CR_GET;
              end
            end
            default: begin
              if (!id_ok) begin
                rsp_stat_d = RS_NOT_LIVE;
                state_d    = ST_RESP;
              end else begin
                cur_d    = id_idx;
                ts_raddr = id_idx;
                state_d  = ST_CHECK;
              end
            end
          endcase
        end
      end

      ST_CHECK: begin
        // status is back; fetch the links in case the timer must be unlinked
        nx_raddr = cur_q;
        pv_raddr = cur_q;
        ls_raddr = cur_q;
        if (tstat_e'(ts_rdata) == TS_FREE) begin
          rsp_stat_d = RS_NOT_LIVE;
          state_d    = ST_RESP;
        end else if (tstat_e'(ts_rdata) == TS_QUEUED) begin
          state_d = ST_UNLINK;
        end else if (cmd_q == CMD_REARM) begin
          state_d = ST_QUEUE;
        end else begin
          state_d = ST_DESTROY;
        end
      end

      ST_CR_GET: begin
        cur_d    = pop_id;
        ts_we    = 1'b1; ts_idx = pop_id; ts_val = TS_IDLE;
        rsp_id_d = ID_W'(pop_id);
        state_d  = ST_QUEUE;
      end

      ST_UNLINK: begin
        // splice the timer out of whatever list holds it
        if (up_p[PW-1]) begin
          if (up_l == DUE) begin
            due_head_d = up_n;
          end else begin
            hd_we = 1'b1; hd_waddr = up_l[SW-1:0]; hd_wdata = up_n;
          end
        end else begin
          nx_we = 1'b1; nx_waddr = up_p[TIDW-1:0]; nx_wdata = up_n;
        end
        if (up_n[PW-1]) begin
          if (up_l == DUE) begin
            due_tail_d = up_p;
          end else begin
            tl_we = 1'b1; tl_waddr = up_l[SW-1:0]; tl_wdata = up_p;
          end
        end else begin
          pv_we = 1'b1; pv_waddr = up_n[TIDW-1:0]; pv_wdata = up_p;
        end
        ts_we    = 1'b1; ts_val = TS_IDLE;
        rsp_wp_d = (cmd_q == CMD_DESTROY);
        state_d  = (cmd_q == CMD_REARM) ? ST_QUEUE : ST_DESTROY;
      end

      ST_DESTROY: begin
        ts_we      = 1'b1; ts_val = TS_FREE;
        sk_we      = 1'b1;
        free_top_d = free_top_q + 1'b1;
        state_d    = ST_RESP;
      end

      ST_QUEUE: begin
        ex_we = 1'b1;
        ret_d = ST_RESP;
        if (dly_q == '0) begin
          lst_d   = DUE;
          state_d = ST_APP;
        end else begin
          state_d = ST_PLACED;
        end
      end

      ST_PLACED: begin
        lst_d    = LW'(pl_slot);
        tl_raddr = pl_slot;
        state_d  = ST_APP;
      end

      ST_APP: begin
        nx_we = 1'b1; nx_waddr = cur_q; nx_wdata = NIL;
        pv_we = 1'b1; pv_waddr = cur_q; pv_wdata = tailv;
        ls_we = 1'b1;
        ts_we = 1'b1; ts_val = TS_QUEUED;
        if (lst_q == DUE) begin
          due_tail_d = {1'b0, cur_q};
        end else begin
          tl_we = 1'b1; tl_waddr = lst_q[SW-1:0]; tl_wdata = {1'b0, cur_q};
        end
        if (tailv[PW-1]) begin
          if (lst_q == DUE) begin
            due_head_d = {1'b0, cur_q};
          end else begin
            hd_we = 1'b1; hd_waddr = lst_q[SW-1:0]; hd_wdata = {1'b0, cur_q};
          end
          state_d = ret_q;
        end else begin
          tlp_d   = tailv;
          state_d = ST_APP_LINK;
        end
      end

      ST_APP_LINK: begin
        nx_we = 1'b1; nx_waddr = tlp_q[TIDW-1:0]; nx_wdata = {1'b0, cur_q};
        state_d = ret_q;
      end

      ST_CAS_HEAD: begin
        cslot_d  = cas_slot[SW-1:0];
        czero_d  = (cas_idx == '0);
        hd_raddr = cas_slot[SW-1:0];
        state_d  = ST_CAS_CLR;
      end

      ST_CAS_CLR: begin
        walk_d = hd_rdata;
        hd_we = 1'b1; hd_waddr = cslot_q;
        tl_we = 1'b1; tl_waddr = cslot_q;
        state_d = ST_CAS_WALK;
      end

      ST_CAS_WALK: begin
        if (walk_q[PW-1]) begin
          // a zero index at this level carries into the next one
          if (czero_q && lvl_q != LVW'(FAR_LEVELS - 1)) begin
            lvl_d   = lvl_q + 1'b1;
            state_d = ST_CAS_HEAD;
          end else begin
            state_d = ST_NEAR_RD;
          end
        end else begin
          cur_d    = walk_q[TIDW-1:0];
          nx_raddr = walk_q[TIDW-1:0];
          ex_raddr = walk_q[TIDW-1:0];
          state_d  = ST_CAS_RD;
        end
      end

      ST_CAS_RD: begin
        walk_d  = nx_rdata;
        pl_exp  = ex_rdata;
        pl_base = tick_q;
        ret_d   = ST_CAS_WALK;
        state_d = ST_PLACED;
      end

      ST_NEAR_RD: begin
        hd_raddr = SW'(tick_q[NEAR_BITS-1:0]);
        tl_raddr = SW'(tick_q[NEAR_BITS-1:0]);
        state_d  = ST_NEAR_SPL;
      end

      ST_NEAR_SPL: begin
        // append the whole near slot to the due list in one splice
        hd_we = 1'b1; hd_waddr = SW'(tick_q[NEAR_BITS-1:0]);
        tl_we = 1'b1; tl_waddr = SW'(tick_q[NEAR_BITS-1:0]);
        walk_d = due_head_q;
        if (!hd_rdata[PW-1]) begin
          if (due_head_q[PW-1]) begin
            due_head_d = hd_rdata;
            walk_d     = hd_rdata;
          end else begin
            nx_we = 1'b1; nx_waddr = due_tail_q[TIDW-1:0]; nx_wdata = hd_rdata;
          end
          due_tail_d = tl_rdata;
        end
        state_d = ST_DUE_RD;
      end

      ST_DUE_RD: begin
        if (walk_q[PW-1]) begin
          due_head_d = NIL;
          due_tail_d = NIL;
          if (any_q) begin
            state_d = ST_IDLE;
          end else begin
            rsp_id_d = '0;
            state_d  = ST_RESP;
          end
        end else begin
          cur_d    = walk_q[TIDW-1:0];
          nx_raddr = walk_q[TIDW-1:0];
          state_d  = ST_DUE_NX;
        end
      end

      ST_DUE_NX: begin
        walk_d  = nx_rdata;
        state_d = ST_DUE_EMIT;
      end

      ST_DUE_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_id_d    = ID_W'(cur_q);
          out_exp_d   = 1'b1;
          out_stat_d  = RS_OK;
          out_wp_d    = 1'b0;
          out_last_d  = walk_q[PW-1];
          ts_we       = 1'b1; ts_val = TS_IDLE;
          any_d       = 1'b1;
          state_d     = ST_DUE_RD;
        end
      end

      ST_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_id_d    = rsp_id_q;
          out_exp_d   = 1'b0;
          out_stat_d  = rsp_stat_q;
          out_wp_d    = rsp_wp_q;
          out_last_d  = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      ret_q       <= ST_RESP;
      tick_q      <= '0;
      free_top_q  <= PW'(TIMER_COUNT);
      clr_q       <= '0;
      due_head_q  <= NIL;
      due_tail_q  <= NIL;
      cur_q       <= '0;
      walk_q      <= NIL;
      tlp_q       <= NIL;
      lst_q       <= '0;
      lvl_q       <= '0;
      cslot_q     <= '0;
      czero_q     <= 1'b0;
      any_q       <= 1'b0;
      cmd_q       <= CMD_TICK;
      dly_q       <= '0;
      rsp_id_q    <= '0;
      rsp_stat_q  <= RS_OK;
      rsp_wp_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_id_q    <= '0;
      out_exp_q   <= 1'b0;
      out_stat_q  <= RS_OK;
      out_wp_q    <= 1'b0;
      out_last_q  <= 1'b0;
      stk_vld_q   <= '0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      tick_q      <= tick_d;
      free_top_q  <= free_top_d;
      clr_q       <= clr_d;
      due_head_q  <= due_head_d;
      due_tail_q  <= due_tail_d;
      cur_q       <= cur_d;
      walk_q      <= walk_d;
      tlp_q       <= tlp_d;
      lst_q       <= lst_d;
      lvl_q       <= lvl_d;
      cslot_q     <= cslot_d;
      czero_q     <= czero_d;
      any_q       <= any_d;
      cmd_q       <= cmd_d;
      dly_q       <= dly_d;
      rsp_id_q    <= rsp_id_d;
      rsp_stat_q  <= rsp_stat_d;
      rsp_wp_q    <= rsp_wp_d;
      out_valid_q <= out_valid_d;
      out_id_q    <= out_id_d;
      out_exp_q   <= out_exp_d;
      out_stat_q  <= out_stat_d;
      out_wp_q    <= out_wp_d;
      out_last_q  <= out_last_d;
      if (sk_we) begin
        stk_vld_q[sk_waddr] <= 1'b1;
      end
    end
  end

  assign in_ready_o     = (state_q == ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign timer_id_out_o = out_id_q;
  assign expired_o      = out_exp_q;
  assign status_o       = out_stat_q;
  assign was_pending_o  = out_wp_q;
  assign last_o         = out_last_q;

  // free stack never overfills
  a_free_top_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_top_q <= PW'(TIMER_COUNT))
    else $error("free stack pointer past pool size");

  // an accepted word always starts a multi-cycle sequence
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready still high after accept");

  // due list head and tail are empty together
  a_due_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    due_head_q[PW-1] == due_tail_q[PW-1])
    else $error("due list ends disagree");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for hierarchical_timer_wheel_unit: directed table, then random commands.
// Depends on htw_pkg and the timer wheel RTL; keeps its own wheel predictor.
module testbench;
  import htw_pkg::*;

  localparam int NEAR_BITS   = 8;
  localparam int FAR_BITS    = 6;
  localparam int FAR_LEVELS  = 4;
  localparam int TIMER_COUNT = 64;
  localparam int NEAR_SIZE   = 1 << NEAR_BITS;
  localparam int FAR_SIZE    = 1 << FAR_BITS;
  localparam int SLOT_COUNT  = NEAR_SIZE + FAR_SIZE * FAR_LEVELS;
  localparam int DUE_SLOT    = SLOT_COUNT;
  localparam logic [6:0] NIL = 7'd127;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_WORDS = 300;

  // One output word, as the checker sees it.
  typedef struct packed {
    logic [5:0] id;
    logic       fired;
    logic [1:0] stat;
    logic       pending;
    logic       last;
  } rsp_word_t;

  typedef struct {
    cmd_e        op;
    logic [5:0]  id;
    logic [31:0] delay;
    bit          typed;
    rsp_word_t   rsp;
  } cmd_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready_o;
  logic [1:0] cmd = CMD_TICK;
  logic [5:0] timer_id = '0;
  logic [31:0] delay_ticks = '0;
  logic out_valid_o;
  logic out_ready = 1'b0;
  logic [5:0] timer_id_out_o;
  logic expired_o;
  logic [1:0] status_o;
  logic was_pending_o;
  logic last_o;

  bit quiet = 1'b0;       // no idling on either side while set
  int cycles = 0;
  int mismatches = 0;

  rsp_word_t pending_rsp_q[$];

  // Predictor state: wheel slots plus the due list at DUE_SLOT.
  logic [6:0]  slot_first [0:SLOT_COUNT];
  logic [6:0]  slot_last  [0:SLOT_COUNT];
  logic [6:0]  next_link  [0:TIMER_COUNT-1];
  logic [6:0]  prev_link  [0:TIMER_COUNT-1];
  logic [31:0] due_at     [0:TIMER_COUNT-1];
  tstat_e      life       [0:TIMER_COUNT-1];
  int          home_slot  [0:TIMER_COUNT-1];
  logic [5:0]  free_ids   [0:TIMER_COUNT-1];
  int          free_count;
  logic [31:0] now_tick;

  hierarchical_timer_wheel_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd),
    .timer_id_i    (timer_id),
    .delay_ticks_i (delay_ticks),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready),
    .timer_id_out_o(timer_id_out_o),
    .expired_o     (expired_o),
    .status_o      (status_o),
    .was_pending_o (was_pending_o),
    .last_o        (last_o)
  );

  always #5 clk_i = ~clk_i;

  // Hard stop: far beyond the slowest legal run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: stall about a third of the time unless in a quiet stretch.
  always @(negedge clk_i) begin
    if (rst_ni) out_ready <= quiet || ($urandom_range(99) >= 32);
  end

  // Compare every accepted output word against the oldest expectation.
  always @(posedge clk_i) begin
    rsp_word_t got, want;
    if (out_valid_o && out_ready) begin
      got = '{timer_id_out_o, expired_o, status_o, was_pending_o, last_o};
      if (pending_rsp_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: got %p", got);
      end else begin
        want = pending_rsp_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("word mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  function automatic void wheel_clear();
    for (int s = 0; s <= SLOT_COUNT; s++) begin
      slot_first[s] = NIL;
      slot_last[s]  = NIL;
    end
    for (int t = 0; t < TIMER_COUNT; t++) begin
      next_link[t] = '0;
      prev_link[t] = '0;
      due_at[t]    = '0;
      life[t]      = TS_FREE;
      home_slot[t] = 0;
      free_ids[t]  = 6'(TIMER_COUNT - 1 - t);
    end
    free_count = TIMER_COUNT;
    now_tick = '0;
  endfunction

  function automatic void list_append(int s, int t);
    next_link[t] = NIL;
    prev_link[t] = slot_last[s];
    if (slot_last[s] >= TIMER_COUNT) slot_first[s] = 7'(t);
    else next_link[slot_last[s]] = 7'(t);
    slot_last[s] = 7'(t);
    home_slot[t] = s;
    life[t] = TS_QUEUED;
  endfunction

  function automatic void list_remove(int t);
    int s;
    logic [6:0] p, n;
    s = home_slot[t];
    p = prev_link[t];
    n = next_link[t];
    if (p >= TIMER_COUNT) slot_first[s] = n;
    else next_link[p] = n;
    if (n >= TIMER_COUNT) slot_last[s] = p;
    else prev_link[n] = p;
    life[t] = TS_IDLE;
  endfunction

  // Pick the slot from the distance between expiry and the reference tick.
  function automatic void slot_insert(int t, logic [31:0] ref_tick);
    logic [31:0] span;
    int level, s;
    span = due_at[t] - ref_tick;
    if (span < NEAR_SIZE) begin
      s = int'(due_at[t] & (NEAR_SIZE - 1));
    end else begin
      level = 0;
      span = span >> NEAR_BITS;
      while (span >= FAR_SIZE && level < FAR_LEVELS - 1) begin
        span = span >> FAR_BITS;
        level++;
      end
      s = NEAR_SIZE + FAR_SIZE * level +
          int'((due_at[t] >> (NEAR_BITS + FAR_BITS * level)) & (FAR_SIZE - 1));
    end
    list_append(s, t);
  endfunction

  function automatic void arm_timer(int t, logic [31:0] delay);
    due_at[t] = now_tick + delay;
    if (delay == 0) list_append(DUE_SLOT, t);
    else slot_insert(t, now_tick + 1);
  endfunction

  // Redistribute far slots; climb a level each time an index wraps to zero.
  function automatic void cascade_far();
    int level, idx, s, t, n, guard;
    level = 0;
    do begin
      idx = int'((now_tick >> (NEAR_BITS + level * FAR_BITS)) & (FAR_SIZE - 1));
      s = NEAR_SIZE + FAR_SIZE * level + idx;
      t = slot_first[s];
      slot_first[s] = NIL;
      slot_last[s]  = NIL;
      guard = 0;
      while (t < TIMER_COUNT && guard < TIMER_COUNT) begin
        n = next_link[t];
        slot_insert(t, now_tick);
        t = n;
        guard++;
      end
      level++;
    end while (idx == 0 && level < FAR_LEVELS);
  endfunction

  // Advance the predictor by one command and queue the words it yields.
  function automatic void wheel_apply(logic [1:0] op, logic [5:0] id, logic [31:0] delay);
    int idx, t, n, k;
    bit wp;
    case (op)
      CMD_TICK: begin
        now_tick = now_tick + 1;
        idx = int'(now_tick & (NEAR_SIZE - 1));
        if (idx == 0) cascade_far();
        t = slot_first[idx];
        slot_first[idx] = NIL;
        slot_last[idx]  = NIL;
        while (t < TIMER_COUNT) begin
          n = next_link[t];
          list_append(DUE_SLOT, t);
          t = n;
        end
        t = slot_first[DUE_SLOT];
        k = 0;
        while (t < TIMER_COUNT && k < TIMER_COUNT) begin
          n = next_link[t];
          life[t] = TS_IDLE;
          pending_rsp_q.push_back('{6'(t), 1'b1, RS_OK, 1'b0, n >= TIMER_COUNT});
          k++;
          t = n;
        end
        slot_first[DUE_SLOT] = NIL;
        slot_last[DUE_SLOT]  = NIL;
        if (k == 0) pending_rsp_q.push_back('{6'd0, 1'b0, RS_OK, 1'b0, 1'b1});
      end
      CMD_CREATE: begin
        if (free_count == 0) begin
          pending_rsp_q.push_back('{6'd0, 1'b0, RS_NO_FREE, 1'b0, 1'b1});
        end else begin
          free_count--;
          t = free_ids[free_count];
          life[t] = TS_IDLE;
          arm_timer(t, delay);
          pending_rsp_q.push_back('{6'(t), 1'b0, RS_OK, 1'b0, 1'b1});
        end
      end
      default: begin
        if (life[id] == TS_FREE) begin
          pending_rsp_q.push_back('{id, 1'b0, RS_NOT_LIVE, 1'b0, 1'b1});
        end else if (op == CMD_REARM) begin
          if (life[id] == TS_QUEUED) list_remove(id);
          arm_timer(id, delay);
          pending_rsp_q.push_back('{id, 1'b0, RS_OK, 1'b0, 1'b1});
        end else begin
          wp = (life[id] == TS_QUEUED);
          if (wp) list_remove(id);
          life[id] = TS_FREE;
          if (free_count < TIMER_COUNT) begin
            free_ids[free_count] = id;
            free_count++;
          end
          pending_rsp_q.push_back('{id, 1'b0, RS_OK, wp, 1'b1});
        end
      end
    endcase
  endfunction

  // Hold the word until accepted; on acceptance advance the predictor. A typed row
  // replaces the predicted word with the one written in the table.
  task automatic send_word(cmd_e op, logic [5:0] id, logic [31:0] delay,
                           bit typed, rsp_word_t rsp);
    if (!quiet && $urandom_range(99) < 32) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid    = 1'b1;
    cmd         = op;
    timer_id    = id;
    delay_ticks = delay;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    wheel_apply(op, id, delay);
    if (typed) begin
      void'(pending_rsp_q.pop_back());
      pending_rsp_q.push_back(rsp);
    end
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_delay();
    int r;
    r = $urandom_range(99);
    if (r < 12) return 32'd0;
    if (r < 62) return 32'($urandom_range(1, 300));
    if (r < 80) return 32'($urandom_range(301, 40000));
    if (r < 95) return $urandom;
    return 32'hFFFF_FFFF;
  endfunction

  cmd_row_t directed [] = '{
    '{CMD_TICK,    6'd0,  32'd0,         1, '{6'd0,  1'b0, RS_OK,       1'b0, 1'b1}},
    '{CMD_CREATE,  6'd0,  32'd0,         1, '{6'd0,  1'b0, RS_OK,       1'b0, 1'b1}},
    '{CMD_TICK,    6'd0,  32'd0,         1, '{6'd0,  1'b1, RS_OK,       1'b0, 1'b1}},
    '{CMD_DESTROY, 6'd0,  32'd0,         1, '{6'd0,  1'b0, RS_OK,       1'b0, 1'b1}},
    '{CMD_DESTROY, 6'd0,  32'd0,         1, '{6'd0,  1'b0, RS_NOT_LIVE, 1'b0, 1'b1}},
    '{CMD_REARM,   6'd63, 32'd5,         1, '{6'd63, 1'b0, RS_NOT_LIVE, 1'b0, 1'b1}},
    '{CMD_CREATE,  6'd0,  32'hFFFF_FFFF, 1, '{6'd0,  1'b0, RS_OK,       1'b0, 1'b1}},
    '{CMD_CREATE,  6'd0,  32'd1,         1, '{6'd1,  1'b0, RS_OK,       1'b0, 1'b1}},
    '{CMD_CREATE,  6'd0,  32'd0,         1, '{6'd2,  1'b0, RS_OK,       1'b0, 1'b1}},
    '{CMD_REARM,   6'd1,  32'd0,         1, '{6'd1,  1'b0, RS_OK,       1'b0, 1'b1}},
    '{CMD_TICK,    6'd0,  32'd0,         0, '0},
    '{CMD_DESTROY, 6'd0,  32'd0,         1, '{6'd0,  1'b0, RS_OK,       1'b1, 1'b1}},
    '{CMD_CREATE,  6'd0,  32'd256,       0, '0},
    '{CMD_CREATE,  6'd0,  32'd16384,     0, '0},
    '{CMD_CREATE,  6'd0,  32'h0004_0000, 0, '0},
    '{CMD_CREATE,  6'd0,  32'h0100_0000, 0, '0},
    '{CMD_CREATE,  6'd0,  32'h8000_0000, 0, '0},
    '{CMD_REARM,   6'd1,  32'd3,         0, '0},
    '{CMD_DESTROY, 6'd2,  32'd0,         1, '{6'd2,  1'b0, RS_OK,       1'b0, 1'b1}},
    '{CMD_CREATE,  6'd0,  32'd2,         0, '0},
    '{CMD_TICK,    6'd0,  32'd0,         0, '0},
    '{CMD_TICK,    6'd0,  32'd0,         0, '0},
    '{CMD_TICK,    6'd0,  32'd0,         0, '0},
    '{CMD_DESTROY, 6'd1,  32'd0,         0, '0}
  };

  initial begin
    int r, burst;
    logic [5:0] id;
    wheel_clear();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed[i])
      send_word(directed[i].op, directed[i].id, directed[i].delay,
                directed[i].typed, directed[i].rsp);

    // Let the wheel drain completely before the random part.
    in_valid = 1'b0;
    while (pending_rsp_q.size() != 0) @(negedge clk_i);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      quiet = (i >= 60 && i < 110);
      // Exhaust the pool once, overrunning it by two.
      if (i == 140) begin
        burst = free_count + 2;
        repeat (burst) send_word(CMD_CREATE, 6'($urandom), pick_delay(), 0, '0);
      end
      r = $urandom_range(99);
      // Address a timer that is most likely live, sometimes any id.
      id = ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(15));
      if (r < 78)      send_word(CMD_TICK, 6'($urandom), $urandom, 0, '0);
      else if (r < 88) send_word(CMD_CREATE, 6'($urandom), pick_delay(), 0, '0);
      else if (r < 94) send_word(CMD_REARM, id, pick_delay(), 0, '0);
      else             send_word(CMD_DESTROY, id, $urandom, 0, '0);
    end

    in_valid = 1'b0;
    while (pending_rsp_q.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    if (mismatches == 0 && pending_rsp_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
design/htw_pkg.sv
design/htw_ram.sv
design/htw_place.sv
design/hierarchical_timer_wheel_unit.sv
bench/testbench.sv
